[rtl/aes_pkg.sv]
`default_nettype none
package aes_pkg;

    localparam int NumRounds = 10;
    localparam int NumKeys   = NumRounds + 1;
    localparam logic [63:0] KeyReset = 64'h3030303030303030;
    localparam logic [7:0]  RedPoly  = 8'h1b;

    // Configuration register indexes.
    localparam logic [0:0] RegKeyHigh = 1'b0;
    localparam logic [0:0] RegKeyLow  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [63:0] data_high;
        logic [63:0] data_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_item;

    typedef struct packed {
        logic [127:0] state;
        logic [127:0] rkey;
        logic         enc;
        logic         last;
    } t_round_ctl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xt(input logic [7:0] b);
        xt = {b[6:0], 1'b0} ^ (b[7] ? RedPoly : 8'h00);
    endfunction

    // Byte k of a 128-bit block, byte 0 on top.
    function automatic logic [7:0] byte_of(input logic [127:0] v, input int k);
        byte_of = v[127 - 8*k -: 8];
    endfunction

endpackage
`default_nettype wire

[rtl/aes128_block_cipher_core.sv]
// Channel   Direction  Handshake             Payload
// input     in         i_in_valid/o_in_stall  aes_pkg::t_in_item
// output    out        o_out_valid/i_out_stall aes_pkg::t_out_item
// config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
// From acceptance to result: the first round key is read in the accepting
// cycle, the load state adds it, then ten rounds follow on the shared round
// unit, one per cycle. A result holds in the output register until taken; the
// next item is accepted only once that register is free, so a new item is not
// taken before the last one is through. After reset and after every key write
// the key schedule runs; until it finishes no item and no key write is taken.
// No item is taken while a key write is offered.
`default_nettype none
module aes128_block_cipher_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire aes_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output aes_pkg::t_out_item      o_out_item,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        S_KEY   = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LOAD  = 4'b0100,
        S_ROUND = 4'b1000
    } t_state;

    t_state       r_state;
    logic [63:0]  r_key_high;
    logic [63:0]  r_key_low;
    logic         r_kick;
    logic         r_enc;
    logic [127:0] r_blk;
    logic [3:0]   r_rnd;
    logic         r_out_valid;
    logic [127:0] r_out;
    logic         ke_busy;
    logic         ke_we;
    logic [3:0]   ke_waddr;
    logic [127:0] ke_wdata;
    logic [3:0]   raddr;
    logic [127:0] rkey;
    logic [127:0] rnd_out;
    logic         accept;
    aes_pkg::t_round_ctl ctl;

    // A key write takes precedence over an item offered in the same cycle.
    assign o_cfg_ready = (r_state == S_IDLE) && !r_kick;
    assign o_in_stall  = !((r_state == S_IDLE) && !r_kick && !r_out_valid && !i_cfg_valid);
    assign accept      = i_in_valid && !o_in_stall;

    // Key registers; any write restarts the schedule.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= aes_pkg::KeyReset;
            r_key_low  <= aes_pkg::KeyReset;
            r_kick     <= 1'b1;
        end else begin
            r_kick <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_kick <= 1'b1;
                unique case (i_cfg_index)
                    aes_pkg::RegKeyHigh: r_key_high <= i_cfg_data;
                    aes_pkg::RegKeyLow:  r_key_low  <= i_cfg_data;
                    default:             r_key_low  <= r_key_low;
                endcase
            end
        end
    end

    aes_keyexp u_keyexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_key   ({r_key_high, r_key_low}),
        .o_busy  (ke_busy),
        .o_we    (ke_we),
        .o_waddr (ke_waddr),
        .o_wdata (ke_wdata)
    );

    aes_ram #(.Width(128), .Depth(aes_pkg::NumKeys)) u_keys (
        .i_clk   (i_clk),
        .i_we    (ke_we),
        .i_waddr (ke_waddr),
        .i_wdata (ke_wdata),
        .i_raddr (raddr),
        .o_rdata (rkey)
    );

    // Round key address: the key needed next cycle. The load cycle fetches
    // the key of the first round.
    always_comb begin
        logic [3:0] step;
        step = (r_state == S_ROUND) ? r_rnd + 4'd1 : 4'd1;
        if (accept) begin
            raddr = i_in_item.func ? 4'd0 : 4'(aes_pkg::NumRounds);
        end else if (r_enc) begin
            raddr = step;
        end else begin
            raddr = 4'(aes_pkg::NumRounds) - step;
        end
    end

    assign ctl.state = r_blk;
    assign ctl.rkey  = rkey;
    assign ctl.enc   = r_enc;
    assign ctl.last  = (r_rnd == 4'(aes_pkg::NumRounds));

    aes_round u_round (
        .i_ctl   (ctl),
        .o_state (rnd_out)
    );

    // Sequencer: waits for the key schedule, then load, initial key add, then ten rounds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_KEY;
            r_out_valid <= 1'b0;
            r_rnd       <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_KEY: begin
                    if (!ke_busy && !r_kick) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (r_kick) begin
                        r_state <= S_KEY;
                    end else if (accept) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_ROUND;
                    r_rnd   <= 4'd1;
                end
                S_ROUND: begin
                    r_rnd <= r_rnd + 4'd1;
                    if (ctl.last) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: r_state <= S_KEY;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_enc <= i_in_item.func;
            r_blk <= {i_in_item.data_high, i_in_item.data_low};
        end else if (r_state == S_LOAD) begin
            r_blk <= r_blk ^ rkey;
        end else if (r_state == S_ROUND) begin
            r_blk <= rnd_out;
            if (ctl.last) begin
                r_out <= rnd_out;
            end
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_out_item.result_high = r_out[127:64];
    assign o_out_item.result_low  = r_out[63:0];

    // The round unit never runs while the key store is being written.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> !ke_busy)
        else $error("round during key schedule");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOAD))
        else $error("accepted item not loaded");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_rnd >= 4'd1 && r_rnd <= 4'(aes_pkg::NumRounds)))
        else $error("round count out of range");

endmodule
`default_nettype wire

[rtl/aes_ram.sv]
`default_nettype none
module aes_ram #(
    parameter int Width = 128,
    parameter int Depth = 11
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/aes_round.sv]
`default_nettype none
module aes_round (
    input  wire aes_pkg::t_round_ctl i_ctl,
    output logic [127:0]             o_state
);

    logic [127:0] sub;
    logic [127:0] mixed;
    logic [127:0] added;

    // One round of either direction; the shared datapath for every round.
    always_comb begin
        logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3, c0, c1, c2, c3;
        sub = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                if (i_ctl.enc) begin
                    sub[127 - 8*(k+4*c) -: 8] =
                        aes_pkg::SBOX[aes_pkg::byte_of(i_ctl.state, k + 4*((c+k)&3))];
                end else begin
                    sub[127 - 8*(k+4*((c+k)&3)) -: 8] =
                        aes_pkg::ISBOX[aes_pkg::byte_of(i_ctl.state, k + 4*c)];
                end
            end
        end
        // Encryption mixes before the key, decryption after it.
        added = (i_ctl.enc ? sub : sub ^ i_ctl.rkey);
        mixed = i_ctl.enc ? sub : added;
        for (int c = 0; c < 4; c++) begin
            a0 = aes_pkg::byte_of(added, 4*c);
            a1 = aes_pkg::byte_of(added, 4*c+1);
            a2 = aes_pkg::byte_of(added, 4*c+2);
            a3 = aes_pkg::byte_of(added, 4*c+3);
            if (!i_ctl.enc) begin
                // Inverse mix via a pre-step: u = x^2(a0^a2), v = x^2(a1^a3).
                b0 = aes_pkg::xt(aes_pkg::xt(a0 ^ a2));
                b1 = aes_pkg::xt(aes_pkg::xt(a1 ^ a3));
                a0 = a0 ^ b0;
                a1 = a1 ^ b1;
                a2 = a2 ^ b0;
                a3 = a3 ^ b1;
            end
            b0 = aes_pkg::xt(a0);
            b1 = aes_pkg::xt(a1);
            b2 = aes_pkg::xt(a2);
            b3 = aes_pkg::xt(a3);
            c0 = b0 ^ b1 ^ a1 ^ a2 ^ a3;
            c1 = a0 ^ b1 ^ b2 ^ a2 ^ a3;
            c2 = a0 ^ a1 ^ b2 ^ b3 ^ a3;
            c3 = b0 ^ a0 ^ a1 ^ a2 ^ b3;
            if (!i_ctl.last) begin
                mixed[127 - 32*c -: 32] = {c0, c1, c2, c3};
            end else begin
                mixed[127 - 32*c -: 32] = {a0 ^ b0 ^ b0 ^ a0 ^ aes_pkg::byte_of(added, 4*c),
                                          aes_pkg::byte_of(added, 4*c+1),
                                          aes_pkg::byte_of(added, 4*c+2),
                                          aes_pkg::byte_of(added, 4*c+3)};
            end
        end
        o_state = i_ctl.enc ? (mixed ^ i_ctl.rkey) : mixed;
    end

endmodule
`default_nettype wire

[rtl/aes_keyexp.sv]
`default_nettype none
module aes_keyexp (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_key,
    output logic              o_busy,
    output logic              o_we,
    output logic [3:0]        o_waddr,
    output logic [127:0]      o_wdata
);

    logic [127:0] r_key;
    logic [127:0] n_key;
    logic [7:0]   r_rcon;
    logic [3:0]   r_idx;
    logic         r_busy;

    // Next round key from the current one: one key round per cycle.
    always_comb begin
        logic [31:0] w0, w1, w2, w3, t;
        w0 = r_key[127:96];
        w1 = r_key[95:64];
        w2 = r_key[63:32];
        w3 = r_key[31:0];
        t  = {aes_pkg::SBOX[w3[23:16]] ^ r_rcon, aes_pkg::SBOX[w3[15:8]],
              aes_pkg::SBOX[w3[7:0]], aes_pkg::SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        n_key = {w0, w1, w2, w3};
    end

    // Walks the eleven round keys into the key store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + 4'd1;
            if (r_idx == 4'(aes_pkg::NumRounds)) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_key  <= i_key;
            r_rcon <= 8'h01;
        end else if (r_busy) begin
            r_key  <= n_key;
            r_rcon <= aes_pkg::xt(r_rcon);
        end
    end

    assign o_busy  = r_busy;
    assign o_we    = r_busy;
    assign o_waddr = r_idx;
    assign o_wdata = r_key;

endmodule
`default_nettype wire
